### rtl/rsort_pkg.sv
// rsort_pkg: shared types, constants and key compare for the record sorter
`default_nettype none
package rsort_pkg;
    localparam int MAX_RECORDS_DEF = 32;
    localparam int NAME_BYTES_DEF  = 40;
    localparam int NAME_WORDS      = 5;
    localparam int ID_W            = 24;
    localparam int PROG_W          = 14;
    localparam int SCORE_W         = 32;
    localparam int WORD_W          = 64;
    localparam int NAME_B          = NAME_WORDS * 8;

    typedef struct packed {
        logic [ID_W-1:0]                    id;
        logic [NAME_WORDS-1:0][WORD_W-1:0]  name;
        logic [PROG_W-1:0]                  prog;
        logic [SCORE_W-1:0]                 score;
    } rec_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic mark_emit;
        logic clear_emit;
    } cmd_t;

    // bytes kept in name word w for a name length of nb bytes
    function automatic logic [WORD_W-1:0] keep_mask(input int w, input int nb);
        logic [WORD_W-1:0] m;
        int                v;
        v = nb - w * 8;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (b < v) begin
                m[WORD_W-1-8*b -: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    function automatic logic [7:0] name_byte(input rec_t r, input int k);
        return r.name[NAME_WORDS-1-(k/8)][WORD_W-1-8*(k%8) -: 8];
    endfunction

    // true when record a must come after record b
    function automatic logic goes_after(input rec_t a, input rec_t b, input logic by_name);
        logic       dec;
        logic [7:0] x;
        logic [7:0] y;
        dec = (a.id > b.id);
        if (by_name) begin
            for (int k = NAME_B - 1; k >= 0; k--) begin
                x = name_byte(a, k);
                y = name_byte(b, k);
                if (x != y) begin
                    dec = (x > y);
                end else if (x == 8'h00) begin
                    dec = (a.id > b.id);
                end
            end
        end
        return dec;
    endfunction
endpackage
`default_nettype wire

### rtl/rsort_if.sv
// rsort_if: input and output channel interfaces of the record sorter
`default_nettype none
interface rsort_in_if;
    logic                          valid;
    logic                          ready;
    logic [rsort_pkg::ID_W-1:0]    record_id;
    logic [rsort_pkg::WORD_W-1:0]  name_word_0;
    logic [rsort_pkg::WORD_W-1:0]  name_word_1;
    logic [rsort_pkg::WORD_W-1:0]  name_word_2;
    logic [rsort_pkg::WORD_W-1:0]  name_word_3;
    logic [rsort_pkg::WORD_W-1:0]  name_word_4;
    logic [rsort_pkg::PROG_W-1:0]  program_code;
    logic [rsort_pkg::SCORE_W-1:0] score_bits;
    logic                          last_record;
    modport source (output valid, record_id, name_word_0, name_word_1, name_word_2,
                    name_word_3, name_word_4, program_code, score_bits, last_record,
                    input ready);
    modport sink (input valid, record_id, name_word_0, name_word_1, name_word_2,
                  name_word_3, name_word_4, program_code, score_bits, last_record,
                  output ready);
endinterface

interface rsort_out_if;
    logic                          valid;
    logic                          ready;
    logic [rsort_pkg::ID_W-1:0]    out_id;
    logic [rsort_pkg::WORD_W-1:0]  out_name_0;
    logic [rsort_pkg::WORD_W-1:0]  out_name_1;
    logic [rsort_pkg::WORD_W-1:0]  out_name_2;
    logic [rsort_pkg::WORD_W-1:0]  out_name_3;
    logic [rsort_pkg::WORD_W-1:0]  out_name_4;
    logic [rsort_pkg::PROG_W-1:0]  out_program;
    logic [rsort_pkg::SCORE_W-1:0] out_score;
    logic                          out_last;
    logic                          overflow_flag;
    modport source (output valid, out_id, out_name_0, out_name_1, out_name_2, out_name_3,
                    out_name_4, out_program, out_score, out_last, overflow_flag,
                    input ready);
    modport sink (input valid, out_id, out_name_0, out_name_1, out_name_2, out_name_3,
                  out_name_4, out_program, out_score, out_last, overflow_flag,
                  output ready);
endinterface
`default_nettype wire

### rtl/rsort_ctrl.sv
// rsort_ctrl: sequencer for loading, selection scans and emitting
`default_nettype none
module rsort_ctrl #(
    parameter int MAX_RECORDS = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_last,
    output logic                                in_ready,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                out_last,
    output logic                                overflow,
    output rsort_pkg::cmd_t                     cmd,
    output logic [$clog2(MAX_RECORDS)-1:0]      wr_addr,
    output logic [$clog2(MAX_RECORDS)-1:0]      rd_addr
);
    import rsort_pkg::*;

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            drop_reg, drop_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic [AW-1:0]   pos_reg, pos_next;
    logic            in_acc;
    logic            out_acc;
    logic            has_room;
    logic            scan_end;

    assign in_acc   = in_valid && in_ready;
    assign out_acc  = out_valid && out_ready;
    assign has_room = (count_reg < CW'(MAX_RECORDS));
    assign scan_end = ((CW'(addr_reg) + CW'(1)) == count_reg);

    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = (state_reg == S_EMIT);
    assign out_last  = ((CW'(pos_reg) + CW'(1)) == count_reg);
    assign overflow  = drop_reg;
    assign wr_addr   = count_reg[AW-1:0];
    assign rd_addr   = addr_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        drop_next      = drop_reg;
        addr_next      = addr_reg;
        pos_next       = pos_reg;
        cmd            = '0;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc) begin
                    if (has_room) begin
                        cmd.wr_en  = 1'b1;
                        count_next = count_reg + CW'(1);
                    end else begin
                        drop_next = 1'b1;
                    end
                    if (in_last) begin
                        cmd.clear_emit = 1'b1;
                        addr_next      = '0;
                        pos_next       = '0;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (scan_end) begin
                    state_next = S_DRAIN;
                end else begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_acc) begin
                    cmd.mark_emit = 1'b1;
                    addr_next     = '0;
                    if (out_last) begin
                        count_next = '0;
                        drop_next  = 1'b0;
                        state_next = S_LOAD;
                    end else begin
                        pos_next   = pos_reg + AW'(1);
                        state_next = S_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            addr_reg  <= '0;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            addr_reg  <= addr_next;
            pos_reg   <= pos_next;
        end
    end
endmodule
`default_nettype wire

### rtl/rsort_dp.sv
// rsort_dp: record memory, key compare and running minimum
`default_nettype none
module rsort_dp #(
    parameter int MAX_RECORDS = 32,
    parameter int NAME_BYTES  = 40
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_wdata,
    input  rsort_pkg::cmd_t                     cmd,
    input  wire logic [$clog2(MAX_RECORDS)-1:0] wr_addr,
    input  wire logic [$clog2(MAX_RECORDS)-1:0] rd_addr,
    input  rsort_pkg::rec_t                     in_rec,
    output rsort_pkg::rec_t                     best_rec
);
    import rsort_pkg::*;

    localparam int AW = $clog2(MAX_RECORDS);

    rec_t                   mem [MAX_RECORDS];
    rec_t                   rd_data_reg;
    rec_t                   best_reg;
    rec_t                   wr_rec;
    logic [AW-1:0]          rd_idx_reg;
    logic                   rd_vld_reg;
    logic [AW-1:0]          best_idx_reg;
    logic                   best_vld_reg;
    logic                   by_name_reg;
    logic [MAX_RECORDS-1:0] emitted_reg;
    logic                   take;

    always_comb
    begin
        wr_rec = in_rec;
        for (int w = 0; w < NAME_WORDS; w++) begin
            wr_rec.name[NAME_WORDS-1-w] = in_rec.name[NAME_WORDS-1-w] & keep_mask(w, NAME_BYTES);
        end
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en) begin
            mem[wr_addr] <= wr_rec;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        rd_idx_reg <= rd_addr;
    end

    assign take = rd_vld_reg && !emitted_reg[rd_idx_reg] &&
                  (!best_vld_reg || goes_after(best_reg, rd_data_reg, by_name_reg));

    always_ff @(posedge clk)
    begin
        if (take) begin
            best_reg     <= rd_data_reg;
            best_idx_reg <= rd_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rd_vld_reg   <= 1'b0;
            best_vld_reg <= 1'b0;
            by_name_reg  <= 1'b0;
            emitted_reg  <= '0;
        end else begin
            rd_vld_reg <= cmd.rd_en;
            if (cfg_we) begin
                by_name_reg <= cfg_wdata;
            end
            if (cmd.mark_emit) begin
                best_vld_reg <= 1'b0;
            end else if (take) begin
                best_vld_reg <= 1'b1;
            end
            if (cmd.clear_emit) begin
                emitted_reg <= '0;
            end else if (cmd.mark_emit) begin
                emitted_reg[best_idx_reg] <= 1'b1;
            end
        end
    end

    assign best_rec = best_reg;
endmodule
`default_nettype wire

### rtl/record_sorter_two_keys_unit.sv
// record_sorter_two_keys_unit: top level of the two-key record sorter
// Loads one record word per cycle into a MAX_RECORDS-entry memory until a word
// with last_record set arrives, then emits the stored set in ascending order of
// id, or of name then id when the mode bit loaded from cfg_wdata under cfg_we
// is 1 (bytewise unsigned, stopping where both names hold a zero byte, so a
// prefix sorts first). Equal keys keep arrival order. Words beyond capacity are
// dropped and overflow_flag is raised on every word of that run. Each result is
// found by a selection scan over the memory through its single read port, then
// a drain step, and is held until the output takes it. No input is taken while
// a run is emitted.
`default_nettype none
module record_sorter_two_keys_unit #(
    parameter int MAX_RECORDS = rsort_pkg::MAX_RECORDS_DEF,
    parameter int NAME_BYTES  = rsort_pkg::NAME_BYTES_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cfg_we,
    input  wire logic     cfg_wdata,
    rsort_in_if.sink      in_ch,
    rsort_out_if.source   out_ch
);
    import rsort_pkg::*;

    localparam int AW = $clog2(MAX_RECORDS);

    cmd_t           cmd;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  rd_addr;
    rec_t           in_rec;
    rec_t           best_rec;

    // gather the incoming word into one record
    always_comb
    begin
        in_rec.id      = in_ch.record_id;
        in_rec.name[4] = in_ch.name_word_0;
        in_rec.name[3] = in_ch.name_word_1;
        in_rec.name[2] = in_ch.name_word_2;
        in_rec.name[1] = in_ch.name_word_3;
        in_rec.name[0] = in_ch.name_word_4;
        in_rec.prog    = in_ch.program_code;
        in_rec.score   = in_ch.score_bits;
    end

    // sequencer: load, scan, drain, emit
    rsort_ctrl #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_last   (in_ch.last_record),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_last  (out_ch.out_last),
        .overflow  (out_ch.overflow_flag),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .rd_addr   (rd_addr)
    );

    // memory plus running minimum of the unemitted records
    rsort_dp #(
        .MAX_RECORDS (MAX_RECORDS),
        .NAME_BYTES  (NAME_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .rd_addr   (rd_addr),
        .in_rec    (in_rec),
        .best_rec  (best_rec)
    );

    // the selected record is held stable while the word waits
    assign out_ch.out_id      = best_rec.id;
    assign out_ch.out_name_0  = best_rec.name[4];
    assign out_ch.out_name_1  = best_rec.name[3];
    assign out_ch.out_name_2  = best_rec.name[2];
    assign out_ch.out_name_3  = best_rec.name[1];
    assign out_ch.out_name_4  = best_rec.name[0];
    assign out_ch.out_program = best_rec.prog;
    assign out_ch.out_score   = best_rec.score;
endmodule
`default_nettype wire

### rtl/rsort_chk.sv
// rsort_chk: port-level checks on the record sorter, bound to the top level
`default_nettype none
module rsort_chk (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic in_last,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic out_last
);
    // a waiting result word is not withdrawn
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word withdrawn");

    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken during emit");

    // a closing word stops loading
    a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("loading continued after last word");

    // end of a run reopens the input
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> in_ready && !out_valid)
        else $error("input not reopened after run");
endmodule

bind record_sorter_two_keys_unit rsort_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_last   (in_ch.last_record),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_last  (out_ch.out_last)
);
`default_nettype wire
